@@ sv/drtt_pkg.sv @@
// Shared types and constants for the delayed repeating tick timer.
package drtt_pkg;

    localparam int TIME_W    = 32;
    localparam int DT_W      = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    localparam logic [TIME_W-1:0] MIN_PERIOD_US   = TIME_W'(16667);
    localparam logic [TIME_W-1:0] SHORT_PERIOD_US = TIME_W'(17000);
    localparam logic [TIME_W-1:0] SHORT_CLAMP_US  = TIME_W'(50000);
    localparam logic [TIME_W-1:0] SAT_TIME        = {TIME_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL = 2'd0,
        REG_DELAY    = 2'd1,
        REG_REPEAT   = 2'd2,
        REG_FOREVER  = 2'd3
    } cfg_idx_t;

    // Effective configuration as seen by the step logic
    typedef struct packed {
        logic [TIME_W-1:0] interval;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] repeat_cnt;
        logic              run_forever;
    } cfg_t;

    typedef struct packed {
        logic              fired;
        logic [TIME_W-1:0] fire_time;
        logic              cancelled;
        logic              done;
    } res_t;

endpackage

@@ sv/drtt_cfg.sv @@
// Configuration registers with the minimum-period clamp on interval and delay.
module drtt_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [drtt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [drtt_pkg::CFG_W-1:0]     cfg_wdata,
    output drtt_pkg::cfg_t                 cfg
);

    logic [drtt_pkg::TIME_W-1:0] interval_reg;
    logic [drtt_pkg::TIME_W-1:0] delay_reg;
    logic [drtt_pkg::TIME_W-1:0] repeat_reg;
    logic                        forever_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= drtt_pkg::MIN_PERIOD_US;
            delay_reg    <= drtt_pkg::MIN_PERIOD_US;
            repeat_reg   <= '0;
            forever_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (drtt_pkg::cfg_idx_t'(cfg_index))
                drtt_pkg::REG_INTERVAL: interval_reg <= cfg_wdata;
                drtt_pkg::REG_DELAY:    delay_reg    <= cfg_wdata;
                drtt_pkg::REG_REPEAT:   repeat_reg   <= cfg_wdata;
                drtt_pkg::REG_FOREVER:  forever_reg  <= cfg_wdata[0];
            endcase
        end
    end

    always_comb
    begin
        cfg.interval    = (interval_reg < drtt_pkg::MIN_PERIOD_US) ?
                          drtt_pkg::MIN_PERIOD_US : interval_reg;
        cfg.delay       = (delay_reg < drtt_pkg::MIN_PERIOD_US) ?
                          drtt_pkg::MIN_PERIOD_US : delay_reg;
        cfg.repeat_cnt  = repeat_reg;
        cfg.run_forever = forever_reg;
    end

endmodule

@@ sv/drtt_core.sv @@
// Timer state and the combinational tick update.
module drtt_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [drtt_pkg::DT_W-1:0] dt,
    input  drtt_pkg::cfg_t            cfg,
    output drtt_pkg::res_t            res
);

    logic                        started_reg, started_next;
    logic                        in_delay_reg, in_delay_next;
    logic                        finished_reg, finished_next;
    logic [drtt_pkg::TIME_W-1:0] acc_reg, acc_next;
    logic [drtt_pkg::TIME_W-1:0] fcnt_reg, fcnt_next;

    logic [drtt_pkg::TIME_W:0]   sum;
    logic [drtt_pkg::TIME_W-1:0] acc_sat;
    logic                        per_fire;
    logic [drtt_pkg::TIME_W-1:0] per_time;
    logic                        short_iv;
    logic [drtt_pkg::TIME_W-1:0] fcnt_inc;

    // saturating accumulate
    assign sum      = {1'b0, acc_reg} + (drtt_pkg::TIME_W+1)'(dt);
    assign acc_sat  = sum[drtt_pkg::TIME_W] ? drtt_pkg::SAT_TIME : sum[drtt_pkg::TIME_W-1:0];
    assign fcnt_inc = (fcnt_reg == drtt_pkg::SAT_TIME) ? fcnt_reg : fcnt_reg + 1'b1;
    assign short_iv = (cfg.interval <= drtt_pkg::SHORT_PERIOD_US);

    // periodic phase: short intervals fire every tick with a clamped time
    always_comb
    begin
        if (short_iv)
        begin
            per_fire = 1'b1;
            per_time = (acc_sat < drtt_pkg::SHORT_CLAMP_US) ? acc_sat : drtt_pkg::SHORT_CLAMP_US;
        end
        else
        begin
            per_fire = (acc_sat >= cfg.interval);
            per_time = acc_sat;
        end
    end

    always_comb
    begin
        started_next  = started_reg;
        in_delay_next = in_delay_reg;
        finished_next = finished_reg;
        acc_next      = acc_reg;
        fcnt_next     = fcnt_reg;
        res.fired     = 1'b0;
        res.fire_time = '0;
        res.cancelled = 1'b0;

        if (finished_reg)
        begin
            // ignored tick
        end
        else if (!started_reg)
        begin
            started_next = 1'b1;
            acc_next     = '0;
            fcnt_next    = '0;
        end
        else if (cfg.run_forever && !in_delay_reg)
        begin
            acc_next = per_fire ? '0 : acc_sat;
            if (per_fire)
            begin
                res.fired     = 1'b1;
                res.fire_time = per_time;
            end
        end
        else
        begin
            acc_next = acc_sat;
            if (in_delay_reg)
            begin
                if (acc_sat >= cfg.delay)
                begin
                    acc_next      = acc_sat - cfg.delay;
                    res.fired     = 1'b1;
                    res.fire_time = cfg.interval;
                    fcnt_next     = fcnt_inc;
                    in_delay_next = 1'b0;
                end
            end
            else if (per_fire)
            begin
                acc_next      = '0;
                res.fired     = 1'b1;
                res.fire_time = per_time;
                fcnt_next     = fcnt_inc;
            end
            if (!cfg.run_forever && (fcnt_next > cfg.repeat_cnt))
            begin
                res.cancelled = 1'b1;
                finished_next = 1'b1;
            end
        end
        res.done = finished_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            in_delay_reg <= 1'b1;
            finished_reg <= 1'b0;
            acc_reg      <= '0;
            fcnt_reg     <= '0;
        end
        else if (step)
        begin
            started_reg  <= started_next;
            in_delay_reg <= in_delay_next;
            finished_reg <= finished_next;
            acc_reg      <= acc_next;
            fcnt_reg     <= fcnt_next;
        end
    end

endmodule

@@ sv/delayed_repeating_tick_timer_top.sv @@
// Top level of the delayed repeating tick timer: input stage, tick logic, result stage.
// Each accepted tick item carries dt_us, the microseconds since the previous
// tick, and yields exactly one result item. The first tick after reset only
// arms the timer. After that the timer waits for delay_us, fires once
// reporting the interval, then fires whenever interval_us has accumulated,
// reporting the accumulated time (short intervals of 17000 us or less fire
// on every tick, time clamped to 50000 us). Interval and delay are taken as at
// least 16667 us. In counted mode (run_forever = 0) the timer cancels once its
// fire count exceeds repeat_count; done_res then stays high and ticks are
// ignored. Throughput is one item per clock unless the result stage is stalled;
// each item passes the input register, then the tick update into the result register.
// The saturating accumulate plus compare in drtt_core sets the cycle time.
// Configuration writes belong to idle periods and take effect on the next tick.
module delayed_repeating_tick_timer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [drtt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [drtt_pkg::CFG_W-1:0]     cfg_wdata,
    // tick input
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [drtt_pkg::DT_W-1:0]      dt_us,
    // result output
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           fired,
    output logic [drtt_pkg::TIME_W-1:0]    fire_time_us,
    output logic                           cancelled,
    output logic                           done_res
);

    drtt_pkg::cfg_t cfg;
    drtt_pkg::res_t core_res;

    logic                      in_valid_reg;
    logic [drtt_pkg::DT_W-1:0] dt_reg;
    logic                      res_valid_reg;
    drtt_pkg::res_t            res_reg;
    logic                      advance;
    logic                      step;

    // The result stage moves when it is empty or its item is being taken;
    // the input register holds an item only while that stage is blocked.
    assign advance  = !res_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    drtt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    drtt_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .dt    (dt_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            dt_reg <= dt_us;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= core_res;
        end
    end

    assign out_valid    = res_valid_reg;
    assign fired        = res_reg.fired;
    assign fire_time_us = res_reg.fire_time;
    assign cancelled    = res_reg.cancelled;
    assign done_res     = res_reg.done;

endmodule

@@ sv/drtt_checker.sv @@
// Port-level checks for the delayed repeating tick timer, bound to the top level.
module drtt_sva (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        fired,
    input logic [drtt_pkg::TIME_W-1:0] fire_time_us,
    input logic                        cancelled,
    input logic                        done_res
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fire_time_us) && $stable(fired)
            && $stable(cancelled) && $stable(done_res))
        else $error("result item changed under stall");

    // no time is reported without a fire
    a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !fired |-> fire_time_us == '0)
        else $error("fire time nonzero without fire");

    // the cancelling item already reports done
    a_cancel_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cancelled |-> done_res)
        else $error("cancel without done");

    // a finished timer never fires
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res && !cancelled |-> !fired)
        else $error("fire after timer finished");

endmodule

bind delayed_repeating_tick_timer_top drtt_sva u_drtt_sva (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .fired        (fired),
    .fire_time_us (fire_time_us),
    .cancelled    (cancelled),
    .done_res     (done_res)
);
